@@ design/mbps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int unsigned DEF_MAX_PATTERN_BYTES = 16;
  localparam int unsigned PAT_BYTES             = 16;
  localparam int unsigned ADDR_W                = 64;
  localparam int unsigned PLEN_W                = 5;
  localparam int unsigned CFG_DATA_W            = 64;
  localparam int unsigned CFG_ADDR_W            = 6;

  localparam logic [63:0]          RST_PATTERN  = 64'h0;
  localparam logic [PAT_BYTES-1:0] RST_CARE     = 16'hFFFF;
  localparam logic [PLEN_W-1:0]    RST_PLEN     = 5'd16;
  localparam logic [ADDR_W-1:0]    RST_BASE     = 64'h0;
  localparam logic                 RST_FIRST    = 1'b1;

  typedef enum logic [2:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_BASE_ADDR    = 3'd4,
    REG_FIRST_ONLY   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_end;
  } in_item_t;

  typedef struct packed {
    logic              match_found;
    logic [ADDR_W-1:0] match_address;
    logic              not_found;
    logic              last_of_region;
  } out_item_t;

endpackage

@@ design/mbps_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_match
// Parallel masked compare of the byte window against the pattern.
// ----------------------------------------------------------------------------
module mbps_match #(
  parameter int unsigned MAX_PATTERN_BYTES = mbps_pkg::DEF_MAX_PATTERN_BYTES,
  parameter int unsigned LEN_W             = $clog2(MAX_PATTERN_BYTES + 1)
) (
  input  logic [MAX_PATTERN_BYTES-1:0][7:0]  window_i,
  input  logic [mbps_pkg::PAT_BYTES-1:0][7:0] pattern_i,
  input  logic [mbps_pkg::PAT_BYTES-1:0]      care_i,
  input  logic [LEN_W-1:0]                    len_i,
  output logic                                hit_o
);

  localparam int unsigned IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  logic [MAX_PATTERN_BYTES-1:0] pos_ok;

  // pattern position i lines up with window slot len-1-i (slot 0 is newest)
  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_pos
    if (i < mbps_pkg::PAT_BYTES) begin : g_cmp
      logic [LEN_W-1:0] widx;
      assign widx      = len_i - LEN_W'(i + 1);
      assign pos_ok[i] = (LEN_W'(i) >= len_i) || !care_i[i] ||
                         (window_i[widx[IDX_W-1:0]] == pattern_i[i]);
    end else begin : g_wild
      assign pos_ok[i] = 1'b1;
    end
  end

  assign hit_o = &pos_ok;

endmodule

@@ design/masked_byte_pattern_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Sliding-window scan of a byte stream for a masked pattern of up to 16 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one region byte per item (data_byte, region_end), valid/ready.
//   out channel : one result item per input item, in order, valid/ready.
//   APB port    : six 64-bit registers at byte address 8*i; pready tied high.
//                 Write registers only while the scanner is empty.
// Timing:
//   Two register stages: window/offset stage, then compare and address add
//   into the result register. out_valid rises when an item moves from stage 1
//   into it. Throughput is one item per cycle while results are taken.
// Reset:
//   Window, byte count and match flag clear; registers take their defaults
//   (care mask all ones, length 16, first-only set).
// Stall:
//   While the receiver holds off, the result register holds and one more item
//   sits in the first stage; in_ready then drops until the result is taken.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner #(
  parameter int unsigned MAX_PATTERN_BYTES = mbps_pkg::DEF_MAX_PATTERN_BYTES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  mbps_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mbps_pkg::out_item_t               out_item_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mbps_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [mbps_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int unsigned CMP_W = (LEN_W > mbps_pkg::PLEN_W) ? LEN_W : mbps_pkg::PLEN_W;
  localparam int unsigned AW    = mbps_pkg::ADDR_W;

  // configuration registers
  logic [63:0]                     pat_lo_q, pat_hi_q;
  logic [mbps_pkg::PAT_BYTES-1:0]  care_q;
  logic [mbps_pkg::PLEN_W-1:0]     plen_q;
  logic [AW-1:0]                   base_q;
  logic                            first_q;

  mbps_pkg::cfg_reg_e              reg_sel;
  logic                            cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = mbps_pkg::cfg_reg_e'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= mbps_pkg::RST_PATTERN;
      pat_hi_q <= mbps_pkg::RST_PATTERN;
      care_q   <= mbps_pkg::RST_CARE;
      plen_q   <= mbps_pkg::RST_PLEN;
      base_q   <= mbps_pkg::RST_BASE;
      first_q  <= mbps_pkg::RST_FIRST;
    end else if (cfg_wr) begin
      case (reg_sel)
        mbps_pkg::REG_PATTERN_LOW:  pat_lo_q <= pwdata;
        mbps_pkg::REG_PATTERN_HIGH: pat_hi_q <= pwdata;
        mbps_pkg::REG_CARE_MASK:    care_q   <= pwdata[mbps_pkg::PAT_BYTES-1:0];
        mbps_pkg::REG_PATTERN_LEN:  plen_q   <= pwdata[mbps_pkg::PLEN_W-1:0];
        mbps_pkg::REG_BASE_ADDR:    base_q   <= pwdata;
        mbps_pkg::REG_FIRST_ONLY:   first_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      mbps_pkg::REG_PATTERN_LOW:  prdata = pat_lo_q;
      mbps_pkg::REG_PATTERN_HIGH: prdata = pat_hi_q;
      mbps_pkg::REG_CARE_MASK:    prdata = 64'(care_q);
      mbps_pkg::REG_PATTERN_LEN:  prdata = 64'(plen_q);
      mbps_pkg::REG_BASE_ADDR:    prdata = base_q;
      mbps_pkg::REG_FIRST_ONLY:   prdata = 64'(first_q);
      default:                    prdata = '0;
    endcase
  end

  // effective length, clamped to 1..MAX_PATTERN_BYTES
  logic [CMP_W-1:0] plen_ext;
  logic [LEN_W-1:0] len_eff, len_m1;

  assign plen_ext = CMP_W'(plen_q);

  always_comb begin
    priority if (plen_ext == '0) begin
      len_eff = LEN_W'(1);
    end else if (plen_ext > CMP_W'(MAX_PATTERN_BYTES)) begin
      len_eff = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len_eff = LEN_W'(plen_ext);
    end
  end

  assign len_m1 = len_eff - LEN_W'(1);

  // handshake
  logic s1_valid_q, out_valid_q;
  logic s1_adv, in_acc, s1_move;

  assign s1_adv      = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_acc      = in_valid_i && in_ready_o;
  assign s1_move     = s1_valid_q && s1_adv;
  assign out_valid_o = out_valid_q;

  // stage 1: window and offset
  logic [MAX_PATTERN_BYTES-1:0][7:0] window_q, window_d;
  logic [AW-1:0]                     seen_q, seen_d;
  logic                              s1_last_q, s1_ge_q;
  logic [AW-1:0]                     s1_off_q;

  always_comb begin
    for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--) begin
      window_d[i] = window_q[i-1];
    end
    window_d[0] = in_item_i.data_byte;
  end

  always_comb begin
    priority if (in_item_i.region_end) begin
      seen_d = '0;
    end else if (&seen_q) begin
      seen_d = seen_q;
    end else begin
      seen_d = seen_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= '0;
      seen_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        window_q   <= window_d;
        seen_q     <= seen_d;
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_last_q <= in_item_i.region_end;
      s1_ge_q   <= seen_q >= AW'(len_m1);
      s1_off_q  <= seen_q - AW'(len_m1);
    end
  end

  // stage 2: compare, first-only filter, address
  logic hit, seen_any, report;
  mbps_pkg::out_item_t out_item_q;
  logic                match_seen_q;

  mbps_match #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .LEN_W             (LEN_W)
  ) u_match (
    .window_i  (window_q),
    .pattern_i ({pat_hi_q, pat_lo_q}),
    .care_i    (care_q),
    .len_i     (len_eff),
    .hit_o     (hit)
  );

  assign seen_any = match_seen_q || (hit && s1_ge_q);
  assign report   = hit && s1_ge_q && !(first_q && match_seen_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_seen_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
      if (s1_move) begin
        match_seen_q <= s1_last_q ? 1'b0 : seen_any;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_item_q.match_found    <= report;
      out_item_q.match_address  <= report ? (base_q + s1_off_q) : '0;
      out_item_q.not_found      <= s1_last_q && !seen_any;
      out_item_q.last_of_region <= s1_last_q;
    end
  end

  assign out_item_o = out_item_q;

endmodule
